// File: design/sdrrip_pkg.sv
// Package: shared types, constants and codes of the DRRIP/SHiP replacement unit.
`timescale 1ns / 1ps
package sdrrip_pkg;

    // Default geometry
    localparam int SETS_DEF     = 2048;
    localparam int WAYS_DEF     = 16;
    localparam int SIG_BITS_DEF = 6;
    localparam int LEADERS_DEF  = 64;

    // Widest internal fields over the whole parameter range
    localparam int MAX_SET_W = 16;
    localparam int MAX_WAY_W = 5;
    localparam int MAX_SIG_W = 12;

    // Depth of the queue between front and back
    localparam int QDEPTH = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_ODDS  = 2'd1;
    localparam logic [1:0] THRESHOLD_RST = 2'd3;
    localparam logic [5:0] FAR_ODDS_RST  = 6'd1;

    // Ages and counters
    localparam logic [1:0] AGE_NEAR   = 2'd0;
    localparam logic [1:0] AGE_LONG   = 2'd2;
    localparam logic [1:0] AGE_FAR    = 2'd3;
    localparam logic [1:0] CNT_MAX    = 2'd3;
    localparam logic [1:0] CNT_MIN    = 2'd0;
    localparam logic [1:0] OUTCOME_RST = 2'd1;
    localparam logic [1:0] HOT_LEVEL  = 2'd2;

    // Action codes
    localparam logic ACT_VICTIM = 1'b0;
    localparam logic ACT_UPDATE = 1'b1;

    // Classified request handed from front to back
    typedef struct packed {
        logic                 act;
        logic [MAX_SET_W-1:0] set;
        logic [MAX_WAY_W-1:0] way;
        logic [63:0]          addr;
        logic [MAX_SIG_W-1:0] sig;
        logic                 hit;
        logic [4:0]           draw;
    } item_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_VICT,
        ST_UPD1,
        ST_UPD2
    } state_t;

endpackage

// File: design/sdrrip_front.sv
// Front end: accepts request beats, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module sdrrip_front #(
    parameter int SETS     = sdrrip_pkg::SETS_DEF,
    parameter int WAYS     = sdrrip_pkg::WAYS_DEF,
    parameter int SIG_BITS = sdrrip_pkg::SIG_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic                action,
    input  logic [10:0]         set_index,
    input  logic [3:0]          way,
    input  logic [63:0]         addr,
    input  logic [63:0]         pc,
    input  logic                hit,
    input  logic [4:0]          random_draw,
    output sdrrip_pkg::item_t   item,
    output logic                item_valid,
    input  logic                item_take
);

    sdrrip_pkg::item_t cls;
    sdrrip_pkg::item_t q_reg [sdrrip_pkg::QDEPTH];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push;
    logic       do_pop;
    logic [31:0] set_r;
    logic [31:0] way_r;
    logic [sdrrip_pkg::MAX_SIG_W-1:0] sig_raw;
    logic [sdrrip_pkg::MAX_SIG_W-1:0] sig_mask;

    // Reduce set and way into range, fold the PC into a signature
    always_comb
    begin
        set_r = 32'(set_index);
        for (int k = 3; k >= 0; k--)
        begin
            if (set_r >= (32'(SETS) << k))
                set_r = set_r - (32'(SETS) << k);
        end
        way_r = 32'(way);
        for (int k = 2; k >= 0; k--)
        begin
            if (way_r >= (32'(WAYS) << k))
                way_r = way_r - (32'(WAYS) << k);
        end
        sig_mask = (sdrrip_pkg::MAX_SIG_W'(1) << SIG_BITS) - sdrrip_pkg::MAX_SIG_W'(1);
        sig_raw  = pc[sdrrip_pkg::MAX_SIG_W+1:2] ^ pc[sdrrip_pkg::MAX_SIG_W+7:8];
        cls.act  = action;
        cls.set  = set_r[sdrrip_pkg::MAX_SET_W-1:0];
        cls.way  = way_r[sdrrip_pkg::MAX_WAY_W-1:0];
        cls.addr = addr;
        cls.sig  = sig_raw & sig_mask;
        cls.hit  = hit;
        cls.draw = random_draw;
    end

    assign full       = (cnt_reg == 2'(sdrrip_pkg::QDEPTH));
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = q_reg[rp_reg];
    assign do_push    = push && !full;
    assign do_pop     = item_take && item_valid;

    // Advance pointers and fill count
    always_comb
    begin
        wp_next  = do_push ? ~wp_reg : wp_reg;
        rp_next  = do_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Hold queued beats
    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wp_reg] <= cls;
    end

endmodule

// File: design/sdrrip_back.sv
// Back end: sequencer, state memories, configuration and result queue.
`timescale 1ns / 1ps
module sdrrip_back #(
    parameter int SETS     = sdrrip_pkg::SETS_DEF,
    parameter int WAYS     = sdrrip_pkg::WAYS_DEF,
    parameter int SIG_BITS = sdrrip_pkg::SIG_BITS_DEF,
    parameter int LEADERS  = sdrrip_pkg::LEADERS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sdrrip_pkg::item_t                   item,
    input  logic                                item_valid,
    output logic                                item_take,
    input  logic                                cfg_we,
    input  logic [sdrrip_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sdrrip_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                                empty,
    input  logic                                pop,
    output logic [3:0]                          victim_way,
    output logic [1:0]                          new_age
);

    localparam int SW    = $clog2(SETS);
    localparam int WW    = $clog2(WAYS);
    localparam int SE    = 1 << SIG_BITS;
    localparam int CLR_N = (SETS > SE) ? SETS : SE;
    localparam int CLW   = $clog2(CLR_N);
    localparam int AROW  = 2 * WAYS;
    localparam int SROW  = SIG_BITS * WAYS;

    sdrrip_pkg::state_t state_reg, state_next;
    sdrrip_pkg::item_t  it_reg;
    logic [CLW-1:0]     clr_reg, clr_next;
    logic [1:0]         thr_reg;
    logic [5:0]         odds_reg;

    // Memories and their registered read data
    logic [AROW-1:0]     age_mem [SETS];
    logic [SROW-1:0]     sig_mem [SETS];
    logic [63:0]         pa_mem  [SETS];
    logic [63:0]         ps_mem  [SETS];
    logic [1:0]          sk_mem  [SETS];
    logic [1:0]          oc_mem  [SE];
    logic [AROW-1:0]     age_rd;
    logic [SROW-1:0]     sig_rd;
    logic [63:0]         pa_rd;
    logic [63:0]         ps_rd;
    logic [1:0]          sk_rd;
    logic [1:0]          oc_rd;

    logic [63:0]         stride_reg;
    logic                lastnz_reg;
    logic [1:0]          ocsig_reg;

    logic                clearing;
    logic                clr_set_ok;
    logic                clr_oc_ok;
    logic [SW-1:0]       set_w;
    logic [WW-1:0]       way_w;
    logic [SIG_BITS-1:0] sig_w;
    logic [SIG_BITS-1:0] old_sig;
    logic [SIG_BITS-1:0] oc_raddr;
    logic                oc_re;

    // Victim search signals
    logic                any3, any2, any1;
    logic [1:0]          lift;
    logic [AROW-1:0]     aged_row;
    logic [WW-1:0]       vict_w;

    // Update signals
    logic                match;
    logic [1:0]          sk_new;
    logic [1:0]          oc_inc;
    logic [1:0]          oc_dec;
    logic [1:0]          sig_eff;
    logic                bimodal;
    logic [1:0]          miss_age;
    logic [1:0]          upd_age;
    logic [AROW-1:0]     upd_row;
    logic [SROW-1:0]     upd_sig_row;

    // Memory write controls
    logic                row_we;
    logic [SW-1:0]       row_wa;
    logic [AROW-1:0]     age_wd;
    logic                sig_we;
    logic [SROW-1:0]     sig_wd;
    logic                pst_we;
    logic [63:0]         pa_wd;
    logic [63:0]         ps_wd;
    logic [1:0]          sk_wd;
    logic                oc_we;
    logic [SIG_BITS-1:0] oc_wa;
    logic [1:0]          oc_wd;

    // Result queue
    logic                res_push;
    logic [WW-1:0]       res_wayi;
    logic [1:0]          res_age;
    logic [WW+3:0]       res_wext;
    logic [5:0]          oq_reg [2];
    logic                oq_wp_reg, oq_rp_reg;
    logic [1:0]          oq_cnt_reg;
    logic                oq_pop;

    assign set_w   = it_reg.set[SW-1:0];
    assign way_w   = it_reg.way[WW-1:0];
    assign sig_w   = it_reg.sig[SIG_BITS-1:0];
    assign old_sig = sig_rd[way_w*SIG_BITS +: SIG_BITS];
    assign clearing   = (state_reg == sdrrip_pkg::ST_CLEAR);
    assign clr_set_ok = clearing && (32'(clr_reg) < 32'(SETS));
    assign clr_oc_ok  = clearing && (32'(clr_reg) < 32'(SE));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        unique case (state_reg)
            sdrrip_pkg::ST_CLEAR:
            begin
                clr_next = clr_reg + CLW'(1);
                if (32'(clr_reg) == 32'(CLR_N - 1))
                    state_next = sdrrip_pkg::ST_IDLE;
            end
            sdrrip_pkg::ST_IDLE:
            begin
                if (item_take)
                    state_next = (item.act == sdrrip_pkg::ACT_VICTIM) ?
                                 sdrrip_pkg::ST_VICT : sdrrip_pkg::ST_UPD1;
            end
            sdrrip_pkg::ST_VICT: state_next = sdrrip_pkg::ST_IDLE;
            sdrrip_pkg::ST_UPD1: state_next = sdrrip_pkg::ST_UPD2;
            sdrrip_pkg::ST_UPD2: state_next = sdrrip_pkg::ST_IDLE;
            default:             state_next = sdrrip_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        item_take = 1'b0;
        res_push  = 1'b0;
        oc_re     = 1'b0;
        unique case (state_reg)
            sdrrip_pkg::ST_IDLE:
            begin
                item_take = item_valid && (oq_cnt_reg != 2'd2);
                oc_re     = item_take;
            end
            sdrrip_pkg::ST_UPD1: oc_re    = 1'b1;
            sdrrip_pkg::ST_VICT: res_push = 1'b1;
            sdrrip_pkg::ST_UPD2: res_push = 1'b1;
            default:             item_take = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sdrrip_pkg::ST_CLEAR;
            clr_reg   <= '0;
            thr_reg   <= sdrrip_pkg::THRESHOLD_RST;
            odds_reg  <= sdrrip_pkg::FAR_ODDS_RST;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    sdrrip_pkg::CFG_THRESHOLD: thr_reg  <= cfg_data[1:0];
                    sdrrip_pkg::CFG_FAR_ODDS:  odds_reg <= cfg_data;
                    default:                   thr_reg  <= thr_reg;
                endcase
            end
        end
    end

    // Latch the request and the stride step
    always_ff @(posedge clk)
    begin
        if (item_take)
            it_reg <= item;
        if (state_reg == sdrrip_pkg::ST_UPD1)
        begin
            lastnz_reg <= (pa_rd != 64'd0);
            stride_reg <= (pa_rd == 64'd0) ? 64'd0 : it_reg.addr - pa_rd;
            ocsig_reg  <= oc_rd;
        end
    end

    // Victim search: lift the whole row until the oldest way is far
    always_comb
    begin
        any3 = 1'b0;
        any2 = 1'b0;
        any1 = 1'b0;
        for (int w = 0; w < WAYS; w++)
        begin
            any3 = any3 | (age_rd[2*w +: 2] == sdrrip_pkg::AGE_FAR);
            any2 = any2 | age_rd[2*w+1];
            any1 = any1 | (age_rd[2*w +: 2] != 2'd0);
        end
        lift = any3 ? 2'd0 : (any2 ? 2'd1 : (any1 ? 2'd2 : 2'd3));
        for (int w = 0; w < WAYS; w++)
            aged_row[2*w +: 2] = age_rd[2*w +: 2] + lift;
        vict_w = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (aged_row[2*w +: 2] == sdrrip_pkg::AGE_FAR)
                vict_w = WW'(w);
        end
    end

    // Update: streak training, outcome counters, insertion age
    always_comb
    begin
        match = lastnz_reg && (stride_reg != 64'd0) && (stride_reg == ps_rd);
        if (match)
            sk_new = (sk_rd == sdrrip_pkg::CNT_MAX) ? sk_rd : sk_rd + 2'd1;
        else
            sk_new = (sk_rd == sdrrip_pkg::CNT_MIN) ? sk_rd : sk_rd - 2'd1;
        oc_inc  = (ocsig_reg == sdrrip_pkg::CNT_MAX) ? ocsig_reg : ocsig_reg + 2'd1;
        oc_dec  = (oc_rd == sdrrip_pkg::CNT_MIN) ? oc_rd : oc_rd - 2'd1;
        sig_eff = (old_sig == sig_w) ? oc_dec : ocsig_reg;
        bimodal = (32'(set_w) >= 32'(SETS - LEADERS));
        if (sk_new >= thr_reg)
            miss_age = sdrrip_pkg::AGE_FAR;
        else if (sig_eff >= sdrrip_pkg::HOT_LEVEL)
            miss_age = sdrrip_pkg::AGE_NEAR;
        else if (bimodal && ({1'b0, it_reg.draw} < odds_reg))
            miss_age = sdrrip_pkg::AGE_FAR;
        else
            miss_age = sdrrip_pkg::AGE_LONG;
        upd_age = it_reg.hit ? sdrrip_pkg::AGE_NEAR : miss_age;
        upd_row = age_rd;
        upd_row[way_w*2 +: 2] = upd_age;
        upd_sig_row = sig_rd;
        upd_sig_row[way_w*SIG_BITS +: SIG_BITS] = sig_w;
    end

    // Memory write selection
    always_comb
    begin
        row_we = clr_set_ok || (state_reg == sdrrip_pkg::ST_VICT) ||
                 (state_reg == sdrrip_pkg::ST_UPD2);
        row_wa = clearing ? clr_reg[SW-1:0] : set_w;
        age_wd = clearing ? {WAYS{sdrrip_pkg::AGE_LONG}} :
                 ((state_reg == sdrrip_pkg::ST_VICT) ? aged_row : upd_row);
        sig_we = clr_set_ok || ((state_reg == sdrrip_pkg::ST_UPD2) && !it_reg.hit);
        sig_wd = clearing ? '0 : upd_sig_row;
        pst_we = clr_set_ok || (state_reg == sdrrip_pkg::ST_UPD2);
        pa_wd  = clearing ? 64'd0 : it_reg.addr;
        ps_wd  = clearing ? 64'd0 : stride_reg;
        sk_wd  = clearing ? sdrrip_pkg::CNT_MIN : sk_new;
        oc_we  = clr_oc_ok || (state_reg == sdrrip_pkg::ST_UPD2);
        oc_wa  = clearing ? clr_reg[SIG_BITS-1:0] : (it_reg.hit ? sig_w : old_sig);
        oc_wd  = clearing ? sdrrip_pkg::OUTCOME_RST : (it_reg.hit ? oc_inc : oc_dec);
        oc_raddr = (state_reg == sdrrip_pkg::ST_IDLE) ? item.sig[SIG_BITS-1:0] : old_sig;
    end

    // Per-way row memories
    always_ff @(posedge clk)
    begin
        if (row_we)
            age_mem[row_wa] <= age_wd;
        if (item_take)
            age_rd <= age_mem[item.set[SW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (sig_we)
            sig_mem[row_wa] <= sig_wd;
        if (item_take)
            sig_rd <= sig_mem[item.set[SW-1:0]];
    end

    // Per-set stride memories
    always_ff @(posedge clk)
    begin
        if (pst_we)
            pa_mem[row_wa] <= pa_wd;
        if (item_take)
            pa_rd <= pa_mem[item.set[SW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (pst_we)
            ps_mem[row_wa] <= ps_wd;
        if (item_take)
            ps_rd <= ps_mem[item.set[SW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (pst_we)
            sk_mem[row_wa] <= sk_wd;
        if (item_take)
            sk_rd <= sk_mem[item.set[SW-1:0]];
    end

    // Signature outcome counters
    always_ff @(posedge clk)
    begin
        if (oc_we)
            oc_mem[oc_wa] <= oc_wd;
        if (oc_re)
            oc_rd <= oc_mem[oc_raddr];
    end

    // Result queue
    assign res_wayi = (state_reg == sdrrip_pkg::ST_VICT) ? vict_w : way_w;
    assign res_age  = (state_reg == sdrrip_pkg::ST_VICT) ? sdrrip_pkg::AGE_FAR : upd_age;
    assign res_wext = (WW+4)'(res_wayi);
    assign empty    = (oq_cnt_reg == 2'd0);
    assign oq_pop   = pop && !empty;
    assign victim_way = oq_reg[oq_rp_reg][5:2];
    assign new_age    = oq_reg[oq_rp_reg][1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wp_reg  <= 1'b0;
            oq_rp_reg  <= 1'b0;
            oq_cnt_reg <= 2'd0;
        end
        else
        begin
            if (res_push)
                oq_wp_reg <= ~oq_wp_reg;
            if (oq_pop)
                oq_rp_reg <= ~oq_rp_reg;
            oq_cnt_reg <= oq_cnt_reg + 2'(res_push) - 2'(oq_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
            oq_reg[oq_wp_reg] <= {res_wext[3:0], res_age};
    end

    // Never push into a full result queue
    a_oq_room: assert property (@(posedge clk) disable iff (!rst_n)
        (oq_cnt_reg == 2'd2) |-> !res_push)
        else $error("result queue overflow");

    // No request taken while the memories are being cleared
    a_no_take_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sdrrip_pkg::ST_CLEAR) |-> !item_take)
        else $error("request taken during clear");

    // A taken update moves from ST_UPD1 to ST_UPD2 and pushes its result there
    a_upd_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sdrrip_pkg::ST_UPD1) |=> (state_reg == sdrrip_pkg::ST_UPD2) && res_push)
        else $error("update did not complete");

    // Victim search always finds a far way
    a_vict_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sdrrip_pkg::ST_VICT) |-> (any3 || (lift != 2'd0)))
        else $error("victim search found no far way");

endmodule

// File: design/ship_drrip_stream_replacement_unit.sv
// Top level of the DRRIP/SHiP replacement unit with stream detection.
// Sequence: a victim request is taken from the front queue while idle and pushes its
// result in ST_VICT; an update passes through ST_UPD1 and ST_UPD2 and pushes in ST_UPD2.
// The back-end sequencer and its single-port set memories handle one request at a time,
// so a new request is taken only once the sequencer is back in idle.
// Reset: asynchronous, active low; afterwards a clearing pass over max(SETS, 2**SIG_BITS)
// addresses (2048 by default) initializes the memories before any request is taken.
`timescale 1ns / 1ps
module ship_drrip_stream_replacement_unit #(
    parameter int SETS     = sdrrip_pkg::SETS_DEF,
    parameter int WAYS     = sdrrip_pkg::WAYS_DEF,
    parameter int SIG_BITS = sdrrip_pkg::SIG_BITS_DEF,
    parameter int LEADERS  = sdrrip_pkg::LEADERS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic                                action,
    input  logic [10:0]                         set_index,
    input  logic [3:0]                          way,
    input  logic [63:0]                         addr,
    input  logic [63:0]                         pc,
    input  logic                                hit,
    input  logic [4:0]                          random_draw,
    output logic                                empty,
    input  logic                                pop,
    output logic [3:0]                          victim_way,
    output logic [1:0]                          new_age,
    input  logic                                cfg_we,
    input  logic [sdrrip_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sdrrip_pkg::CFG_DATA_W-1:0]   cfg_data
);

    sdrrip_pkg::item_t item;
    logic              item_valid;
    logic              item_take;

    // Accept and classify beats
    sdrrip_front #(
        .SETS     (SETS),
        .WAYS     (WAYS),
        .SIG_BITS (SIG_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .action      (action),
        .set_index   (set_index),
        .way         (way),
        .addr        (addr),
        .pc          (pc),
        .hit         (hit),
        .random_draw (random_draw),
        .item        (item),
        .item_valid  (item_valid),
        .item_take   (item_take)
    );

    // Carry out requests against the state memories
    sdrrip_back #(
        .SETS     (SETS),
        .WAYS     (WAYS),
        .SIG_BITS (SIG_BITS),
        .LEADERS  (LEADERS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .empty      (empty),
        .pop        (pop),
        .victim_way (victim_way),
        .new_age    (new_age)
    );

endmodule

// File: bench/tb.sv
// Testbench for the DRRIP/SHiP replacement unit with stream detection.
`timescale 1ns / 1ps
module tb;

    localparam int NSETS    = 2048;
    localparam int NWAYS    = 16;
    localparam int NLEADERS = 64;
    localparam int LIMIT    = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        action = 1'b0;
    logic [10:0] set_index = '0;
    logic [3:0]  way = '0;
    logic [63:0] addr = '0;
    logic [63:0] pc = '0;
    logic        hit = 1'b0;
    logic [4:0]  random_draw = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [3:0]  victim_way;
    logic [1:0]  new_age;
    logic        cfg_we = 1'b0;
    logic [sdrrip_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [sdrrip_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    typedef struct packed {
        logic [3:0] vway;
        logic [1:0] age;
    } outcome_t;

    // Predictor state
    logic [1:0]  age_mem [NSETS*NWAYS];
    logic [5:0]  sig_mem [NSETS*NWAYS];
    logic [1:0]  sig_ctr [64];
    logic [63:0] prior_addr [NSETS];
    logic [63:0] prior_step [NSETS];
    logic [1:0]  streak [NSETS];
    logic [1:0]  threshold;
    logic [5:0]  far_odds;

    outcome_t pending[$];
    int  errors = 0;
    int  cycles = 0;
    int  pop_gap = 0;
    bit  hold_pop = 1'b0;

    ship_drrip_stream_replacement_unit dut (.*);

    always #2 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Compare each accepted result beat against the oldest prediction
    always @(posedge clk)
    begin
        outcome_t e;
        if (rst_n && pop && !empty)
        begin
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result way=%0d age=%0d", $time, victim_way, new_age);
                errors++;
            end
            else
            begin
                e = pending.pop_front();
                if (e.vway !== victim_way)
                begin
                    $display("%0t: victim_way expected %0d actual %0d", $time, e.vway, victim_way);
                    errors++;
                end
                if (e.age !== new_age)
                begin
                    $display("%0t: new_age expected %0d actual %0d", $time, e.age, new_age);
                    errors++;
                end
            end
        end
    end

    // Random pop stalls, mostly short, sometimes long
    always @(negedge clk)
    begin
        if (hold_pop)
            pop <= 1'b0;
        else if (pop_gap > 0)
        begin
            pop <= 1'b0;
            pop_gap <= pop_gap - 1;
        end
        else if ($urandom_range(0, 99) < 3)
        begin
            pop <= 1'b0;
            pop_gap <= $urandom_range(10, 40);
        end
        else if ($urandom_range(0, 99) < 25)
            pop <= 1'b0;
        else
            pop <= 1'b1;
    end

    function automatic void predictor_reset();
        for (int i = 0; i < NSETS*NWAYS; i++)
        begin
            age_mem[i] = sdrrip_pkg::AGE_LONG;
            sig_mem[i] = '0;
        end
        for (int i = 0; i < 64; i++)
            sig_ctr[i] = sdrrip_pkg::OUTCOME_RST;
        for (int i = 0; i < NSETS; i++)
        begin
            prior_addr[i] = '0;
            prior_step[i] = '0;
            streak[i] = '0;
        end
        threshold = sdrrip_pkg::THRESHOLD_RST;
        far_odds = sdrrip_pkg::FAR_ODDS_RST;
    endfunction

    // Compute the expected victim or updated age and advance predictor state
    function automatic outcome_t replacement_predict(logic act, logic [10:0] s, logic [3:0] w,
                                                     logic [63:0] a, logic [63:0] p, logic h,
                                                     logic [4:0] d);
        outcome_t r;
        int base;
        logic [1:0] top;
        logic [63:0] stride;
        logic [5:0] sg, old;
        base = int'(s) * NWAYS;
        if (act == sdrrip_pkg::ACT_VICTIM)
        begin
            top = '0;
            for (int i = 0; i < NWAYS; i++)
                if (age_mem[base+i] > top) top = age_mem[base+i];
            if (top < sdrrip_pkg::AGE_FAR)
                for (int i = 0; i < NWAYS; i++)
                    age_mem[base+i] = age_mem[base+i] + (sdrrip_pkg::AGE_FAR - top);
            r.vway = '0;
            for (int i = NWAYS-1; i >= 0; i--)
                if (age_mem[base+i] == sdrrip_pkg::AGE_FAR) r.vway = 4'(i);
            r.age = age_mem[base + int'(r.vway)];
            return r;
        end
        // Train the stride streak
        stride = (prior_addr[s] == 0) ? 64'd0 : a - prior_addr[s];
        if (prior_addr[s] != 0 && stride != 0 && stride == prior_step[s])
        begin
            if (streak[s] < sdrrip_pkg::CNT_MAX) streak[s]++;
        end
        else if (streak[s] > sdrrip_pkg::CNT_MIN)
            streak[s]--;
        prior_addr[s] = a;
        prior_step[s] = stride;
        sg = 6'((p >> 2) ^ (p >> 8));
        if (h)
        begin
            age_mem[base+w] = sdrrip_pkg::AGE_NEAR;
            if (sig_ctr[sg] < sdrrip_pkg::CNT_MAX) sig_ctr[sg]++;
        end
        else
        begin
            old = sig_mem[base+w];
            if (sig_ctr[old] > sdrrip_pkg::CNT_MIN) sig_ctr[old]--;
            sig_mem[base+w] = sg;
            if (streak[s] >= threshold)
                age_mem[base+w] = sdrrip_pkg::AGE_FAR;
            else if (sig_ctr[sg] >= sdrrip_pkg::HOT_LEVEL)
                age_mem[base+w] = sdrrip_pkg::AGE_NEAR;
            else if (s >= NSETS - NLEADERS && {1'b0, d} < far_odds)
                age_mem[base+w] = sdrrip_pkg::AGE_FAR;
            else
                age_mem[base+w] = sdrrip_pkg::AGE_LONG;
        end
        r.vway = w;
        r.age = age_mem[base+w];
        return r;
    endfunction

    // Send one request beat and queue its prediction
    task automatic send_request(logic act, logic [10:0] s, logic [3:0] w, logic [63:0] a,
                                logic [63:0] p, logic h, logic [4:0] d);
        int gap;
        gap = ($urandom_range(0, 99) < 5) ? $urandom_range(10, 40) :
              ($urandom_range(0, 99) < 40 ? $urandom_range(1, 3) : 0);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        action <= act;
        set_index <= s;
        way <= w;
        addr <= a;
        pc <= p;
        hit <= h;
        random_draw <= d;
        push <= 1'b1;
        do @(posedge clk); while (full);
        pending.push_back(replacement_predict(act, s, w, a, p, h, d));
        @(negedge clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (pending.size() != 0) @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(logic [sdrrip_pkg::CFG_IDX_W-1:0] idx,
                             logic [sdrrip_pkg::CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == sdrrip_pkg::CFG_THRESHOLD) threshold = val[1:0];
        else if (idx == sdrrip_pkg::CFG_FAR_ODDS) far_odds = val;
    endtask

    function automatic logic [10:0] pick_set();
        case ($urandom_range(0, 3))
            0: return 11'($urandom_range(0, NLEADERS-1));
            1: return 11'($urandom_range(NSETS-NLEADERS, NSETS-1));
            2: return 11'($urandom_range(100, 107));
            default: return 11'($urandom);
        endcase
    endfunction

    // Field extremes, both actions, hits and misses, leader sets
    task automatic test_directed();
        send_request(sdrrip_pkg::ACT_VICTIM, 11'd0, 4'd0, '0, '0, 1'b0, 5'd0);
        send_request(sdrrip_pkg::ACT_VICTIM, 11'd2047, 4'd15, '1, '1, 1'b1, 5'd31);
        send_request(sdrrip_pkg::ACT_UPDATE, 11'd2047, 4'd15, '1, '1, 1'b0, 5'd0);
        send_request(sdrrip_pkg::ACT_UPDATE, 11'd2047, 4'd3, 64'h10, '1, 1'b0, 5'd31);
        send_request(sdrrip_pkg::ACT_UPDATE, 11'd0, 4'd0, '0, '0, 1'b1, 5'd0);
        send_request(sdrrip_pkg::ACT_UPDATE, 11'd0, 4'd0, 64'h40, '0, 1'b1, 5'd0);
        send_request(sdrrip_pkg::ACT_UPDATE, 11'd0, 4'd1, 64'h80, '0, 1'b0, 5'd0);
        send_request(sdrrip_pkg::ACT_VICTIM, 11'd0, 4'd0, '0, '0, 1'b0, 5'd0);
        send_request(sdrrip_pkg::ACT_VICTIM, 11'd0, 4'd0, '0, '0, 1'b0, 5'd0);
        send_request(sdrrip_pkg::ACT_UPDATE, 11'd5, 4'd7, 64'h8000_0000_0000_0000,
                     64'h5555_5555_5555_5555, 1'b0, 5'd16);
        send_request(sdrrip_pkg::ACT_UPDATE, 11'd1024, 4'd8, 64'h1234,
                     64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 5'd1);
        send_request(sdrrip_pkg::ACT_VICTIM, 11'd1024, 4'd0, '0, '0, 1'b0, 5'd0);
        drain();
    endtask

    // Strided streams per set with random content, plus noise
    task automatic test_random(int n, int stream_pct);
        logic [10:0] s;
        logic [63:0] a, st, p;
        int run;
        for (int i = 0; i < n; )
        begin
            s = pick_set();
            if ($urandom_range(0, 99) < stream_pct)
            begin
                a = {$urandom, $urandom};
                st = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} :
                     64'($urandom_range(1, 256));
                p = {$urandom, $urandom};
                run = $urandom_range(3, 8);
                for (int k = 0; k < run; k++)
                begin
                    send_request(sdrrip_pkg::ACT_UPDATE, s, 4'($urandom), a, p,
                                 1'($urandom_range(0, 3) == 0), 5'($urandom));
                    a = a + st;
                    i++;
                end
            end
            else
            begin
                p = {$urandom, $urandom};
                if ($urandom_range(0, 1)) p[13:2] = 12'($urandom_range(0, 7));
                send_request(1'($urandom), s, 4'($urandom), {$urandom, $urandom}, p,
                             1'($urandom), 5'($urandom));
                i++;
            end
        end
        drain();
    endtask

    // Sweep register settings, extremes included
    task automatic test_config_sweep();
        logic [sdrrip_pkg::CFG_DATA_W-1:0] odds [4] = '{6'd0, 6'd32, 6'd63, 6'd17};
        for (int t = 0; t < 4; t++)
        begin
            write_reg(sdrrip_pkg::CFG_THRESHOLD, sdrrip_pkg::CFG_DATA_W'(t));
            write_reg(sdrrip_pkg::CFG_FAR_ODDS, odds[t]);
            write_reg(2'd3, 6'h3F);
            test_random(200, 50);
        end
    endtask

    initial
    begin
        predictor_reset();
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random(250, 60);
        // Hold results back so the queue fills and the sender stalls
        hold_pop = 1'b1;
        test_random_burst();
        test_config_sweep();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    task automatic test_random_burst();
        fork
            begin
                repeat (200) @(negedge clk);
                hold_pop = 1'b0;
            end
        join_none
        test_random(60, 40);
    endtask
endmodule
